// ===== rtl/dirty_region_splitter_unit_defines.svh =====
// Assertion macros used by the region queue of the dirty region splitter RTL.
`ifndef DIRTY_REGION_SPLITTER_UNIT_DEFINES_SVH
`define DIRTY_REGION_SPLITTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define DRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DRS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/drs_pkg.sv =====
// Types, constants and helper functions of the dirty region splitter.
package drs_pkg;

  localparam int COORD_BITS  = 16;
  localparam int SCREEN_BITS = 12;
  localparam int CFG_BITS    = 13;
  localparam int CFG_IDX_BITS = 2;
  localparam int KIND_BITS   = 3;
  localparam int NUM_SLOTS   = 5;

  // Working width for coordinate arithmetic: room for +-1 on a coordinate
  // and for comparing against a zero-extended configuration value.
  localparam int WORK_A = COORD_BITS + 2;
  localparam int WORK_B = (SCREEN_BITS + 2 > CFG_BITS + 1) ? SCREEN_BITS + 2 : CFG_BITS + 1;
  localparam int WORK_BITS = (WORK_A > WORK_B) ? WORK_A : WORK_B;

  localparam int SCREEN_LIM = 1 << SCREEN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = CFG_BITS'(240);
  localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = CFG_BITS'(320);

  localparam logic [KIND_BITS-1:0] KIND_TOP    = KIND_BITS'(0);
  localparam logic [KIND_BITS-1:0] KIND_BOTTOM = KIND_BITS'(1);
  localparam logic [KIND_BITS-1:0] KIND_LEFT   = KIND_BITS'(2);
  localparam logic [KIND_BITS-1:0] KIND_RIGHT  = KIND_BITS'(3);
  localparam logic [KIND_BITS-1:0] KIND_NEW    = KIND_BITS'(4);

  typedef logic signed [WORK_BITS-1:0] work_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] old_x_min;
    logic signed [COORD_BITS-1:0] old_y_min;
    logic signed [COORD_BITS-1:0] old_x_max;
    logic signed [COORD_BITS-1:0] old_y_max;
    logic signed [COORD_BITS-1:0] new_x_min;
    logic signed [COORD_BITS-1:0] new_y_min;
    logic signed [COORD_BITS-1:0] new_x_max;
    logic signed [COORD_BITS-1:0] new_y_max;
  } drs_request_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] region_x_min;
    logic [SCREEN_BITS-1:0] region_y_min;
    logic [SCREEN_BITS-1:0] region_x_max;
    logic [SCREEN_BITS-1:0] region_y_max;
    logic [KIND_BITS-1:0]   region_kind;
    logic                   last_region;
  } drs_result_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] x_min;
    logic [SCREEN_BITS-1:0] y_min;
    logic [SCREEN_BITS-1:0] x_max;
    logic [SCREEN_BITS-1:0] y_max;
    logic [KIND_BITS-1:0]   kind;
  } drs_region_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]        keep;
    drs_region_t [NUM_SLOTS-1:0] region;
  } drs_cand_set_t;

  function automatic work_t sext(logic signed [COORD_BITS-1:0] v);
    return work_t'({{(WORK_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

  function automatic work_t smin(work_t a, work_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic work_t smax(work_t a, work_t b);
    return (a > b) ? a : b;
  endfunction

  // Screen size saturated to the addressable range, as a signed work value.
  function automatic work_t screen_limit(logic [CFG_BITS-1:0] size);
    work_t s;
    s = work_t'({{(WORK_BITS-CFG_BITS){1'b0}}, size});
    return (s > work_t'(SCREEN_LIM)) ? work_t'(SCREEN_LIM) : s;
  endfunction

  // A region survives when it is non-empty and touches the screen.
  function automatic logic clip_keep(work_t x0, work_t y0, work_t x1, work_t y1,
                                     work_t w, work_t h);
    return (x1 >= x0) && (y1 >= y0) && !x1[WORK_BITS-1] && !(x0 >= w) &&
           !y1[WORK_BITS-1] && !(y0 >= h);
  endfunction

  function automatic drs_region_t clip_region(work_t x0, work_t y0, work_t x1, work_t y1,
                                              work_t w, work_t h,
                                              logic [KIND_BITS-1:0] kind);
    drs_region_t r;
    work_t cx0;
    work_t cy0;
    work_t cx1;
    work_t cy1;
    cx0 = x0[WORK_BITS-1] ? '0 : x0;
    cy0 = y0[WORK_BITS-1] ? '0 : y0;
    cx1 = (x1 >= w) ? w - work_t'(1) : x1;
    cy1 = (y1 >= h) ? h - work_t'(1) : y1;
    r.x_min = cx0[SCREEN_BITS-1:0];
    r.y_min = cy0[SCREEN_BITS-1:0];
    r.x_max = cx1[SCREEN_BITS-1:0];
    r.y_max = cy1[SCREEN_BITS-1:0];
    r.kind  = kind;
    return r;
  endfunction

endpackage

// ===== rtl/drs_region_calc.sv =====
// Splits the old rectangle into bands and strips and clips every candidate.
module drs_region_calc (
  input  drs_pkg::drs_request_t               rect,
  input  logic [drs_pkg::CFG_BITS-1:0]        screen_width,
  input  logic [drs_pkg::CFG_BITS-1:0]        screen_height,
  output drs_pkg::drs_cand_set_t              cands
);

  drs_pkg::work_t ox0, oy0, ox1, oy1;
  drs_pkg::work_t nx0, ny0, nx1, ny1;
  drs_pkg::work_t ty0, ty1, mid0, mid1, lx1, rx0;
  drs_pkg::work_t w, h;
  logic o_ok, n_ok;

  always_comb begin
    ox0 = drs_pkg::sext(rect.old_x_min);
    oy0 = drs_pkg::sext(rect.old_y_min);
    ox1 = drs_pkg::sext(rect.old_x_max);
    oy1 = drs_pkg::sext(rect.old_y_max);
    nx0 = drs_pkg::sext(rect.new_x_min);
    ny0 = drs_pkg::sext(rect.new_y_min);
    nx1 = drs_pkg::sext(rect.new_x_max);
    ny1 = drs_pkg::sext(rect.new_y_max);
    w = drs_pkg::screen_limit(screen_width);
    h = drs_pkg::screen_limit(screen_height);

    o_ok = (ox1 >= ox0) && (oy1 >= oy0);
    n_ok = (nx1 >= nx0) && (ny1 >= ny0);

    // Without a new rectangle the top band takes the whole old area.
    if (n_ok) begin
      ty1 = drs_pkg::smin(oy1, drs_pkg::smax(oy0, ny0) - drs_pkg::work_t'(1));
      ty0 = drs_pkg::smax(oy0, drs_pkg::smin(oy1, ny1) + drs_pkg::work_t'(1));
    end else begin
      ty1 = oy1;
      ty0 = oy1 + drs_pkg::work_t'(1);
    end
    mid0 = ty1 + drs_pkg::work_t'(1);
    mid1 = ty0 - drs_pkg::work_t'(1);
    lx1  = drs_pkg::smin(ox1, nx0 - drs_pkg::work_t'(1));
    rx0  = drs_pkg::smax(ox0, nx1 + drs_pkg::work_t'(1));

    cands.keep[0] = o_ok && drs_pkg::clip_keep(ox0, oy0, ox1, ty1, w, h);
    cands.keep[1] = o_ok && drs_pkg::clip_keep(ox0, ty0, ox1, oy1, w, h);
    cands.keep[2] = o_ok && n_ok && drs_pkg::clip_keep(ox0, mid0, lx1, mid1, w, h);
    cands.keep[3] = o_ok && n_ok && drs_pkg::clip_keep(rx0, mid0, ox1, mid1, w, h);
    cands.keep[4] = n_ok && drs_pkg::clip_keep(nx0, ny0, nx1, ny1, w, h);

    cands.region[0] = drs_pkg::clip_region(ox0, oy0, ox1, ty1, w, h, drs_pkg::KIND_TOP);
    cands.region[1] = drs_pkg::clip_region(ox0, ty0, ox1, oy1, w, h, drs_pkg::KIND_BOTTOM);
    cands.region[2] = drs_pkg::clip_region(ox0, mid0, lx1, mid1, w, h, drs_pkg::KIND_LEFT);
    cands.region[3] = drs_pkg::clip_region(rx0, mid0, ox1, mid1, w, h, drs_pkg::KIND_RIGHT);
    cands.region[4] = drs_pkg::clip_region(nx0, ny0, nx1, ny1, w, h, drs_pkg::KIND_NEW);
  end

endmodule

// ===== rtl/drs_region_queue.sv =====
// Holds the surviving regions of one request and sends them out one per cycle.
`include "dirty_region_splitter_unit_defines.svh"

module drs_region_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  drs_pkg::drs_cand_set_t cands,
  output logic                   free,
  output logic                   result_valid,
  output drs_pkg::drs_result_t   result
);

  logic [drs_pkg::NUM_SLOTS-1:0]        mask;
  logic [drs_pkg::NUM_SLOTS-1:0]        mask_next;
  drs_pkg::drs_region_t [drs_pkg::NUM_SLOTS-1:0] entries;
  logic [drs_pkg::NUM_SLOTS-1:0]        pick;
  logic [drs_pkg::NUM_SLOTS-1:0]        rest;
  logic                                 load;
  drs_pkg::drs_region_t                 sel;

  always_comb begin
    pick = mask & (~mask + drs_pkg::NUM_SLOTS'(1));
    rest = mask & ~pick;
    // The queue can take a new set when it is empty or sends its last entry now.
    free = (rest == '0);
    load = in_valid && free;
    mask_next = load ? cands.keep : rest;
    sel = '0;
    for (int i = 0; i < drs_pkg::NUM_SLOTS; i++) begin
      if (pick[i]) begin
        sel = entries[i];
      end
    end
    result_valid        = (mask != '0);
    result.region_x_min = sel.x_min;
    result.region_y_min = sel.y_min;
    result.region_x_max = sel.x_max;
    result.region_y_max = sel.y_max;
    result.region_kind  = sel.kind;
    result.last_region  = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= cands.region;
    end
  end

  `DRS_ASSERT_IMP(a_pick_onehot, clk, rst, result_valid, $onehot(pick), "no single entry picked")
  `DRS_ASSERT_IMP(a_load_when_done, clk, rst, load, $countones(mask) <= 1, "set overwritten")
  `DRS_ASSERT_NEXT(a_more_follow, clk, rst, result_valid && !result.last_region, result_valid,
                   "region lost before last")
  `DRS_ASSERT_NEXT(a_idle_after_last, clk, rst,
                   result_valid && result.last_region && !load, !result_valid,
                   "region after last without new set")

endmodule

// ===== rtl/dirty_region_splitter_unit.sv =====
// Dirty region splitter: an accepted request goes through the request register into the region queue.
// A request yielding n regions sends them on consecutive cycles; throughput is set by the
// single result port (at most 5 regions per request), and a new request is taken while regions still go out.
// busy rises while a captured request waits for the region queue to drain.
// Synchronous reset empties the request register and queue and sets the screen to 240x320.
// Results cannot be stalled; each is presented for exactly one cycle.
module dirty_region_splitter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  drs_pkg::drs_request_t             rect,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [drs_pkg::CFG_BITS-1:0]      cfg_data,
  output logic                              result_valid,
  output drs_pkg::drs_result_t              result
);

  logic [drs_pkg::CFG_BITS-1:0] screen_width;
  logic [drs_pkg::CFG_BITS-1:0] screen_height;
  drs_pkg::drs_request_t        rect_reg;
  logic                         in_valid;
  logic                         free;
  logic                         accept;
  drs_pkg::drs_cand_set_t       cands;

  assign cfg_ready = 1'b1;
  assign busy      = in_valid && !free;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= drs_pkg::SCREEN_WIDTH_RESET;
      screen_height <= drs_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        drs_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        drs_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The request register empties into the queue whenever the queue is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (free) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rect_reg <= rect;
    end
  end

  drs_region_calc u_calc (
    .rect          (rect_reg),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .cands         (cands)
  );

  drs_region_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .cands        (cands),
    .free         (free),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the dirty region splitter: region scoreboard, request driver and test sequence.
import drs_pkg::*;

typedef logic signed [COORD_BITS+1:0] span_t;

typedef struct {
  span_t                x0;
  span_t                y0;
  span_t                x1;
  span_t                y1;
  logic [KIND_BITS-1:0] kind;
} area_t;

class region_scoreboard;
  logic [CFG_BITS-1:0] width_q;
  logic [CFG_BITS-1:0] height_q;
  drs_result_t         pending_regions[$];
  int                  mismatch_count;

  function new();
    width_q        = SCREEN_WIDTH_RESET;
    height_q       = SCREEN_HEIGHT_RESET;
    mismatch_count = 0;
  endfunction

  function void set_screen(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    if (idx == REG_SCREEN_WIDTH) begin
      width_q = val;
    end else if (idx == REG_SCREEN_HEIGHT) begin
      height_q = val;
    end
  endfunction

  function span_t lesser(span_t a, span_t b);
    return (a < b) ? a : b;
  endfunction

  function span_t greater(span_t a, span_t b);
    return (a > b) ? a : b;
  endfunction

  // Sizes beyond the addressable range clip as if the screen were exactly that large.
  function span_t screen_span(logic [CFG_BITS-1:0] size);
    span_t s;
    s = span_t'(size);
    if (s > span_t'(SCREEN_LIM)) s = span_t'(SCREEN_LIM);
    return s;
  endfunction

  // Works out the redraw regions of one request and queues them in order.
  function void note_request(drs_request_t req);
    span_t       ox0, oy0, ox1, oy1, nx0, ny0, nx1, ny1;
    span_t       top_end, bottom_start, w, h;
    span_t       lx, ly, hx, hy;
    bit          old_ok, new_ok;
    area_t       cands[$];
    area_t       a;
    drs_result_t found[$];
    drs_result_t r;
    ox0 = span_t'($signed(req.old_x_min));
    oy0 = span_t'($signed(req.old_y_min));
    ox1 = span_t'($signed(req.old_x_max));
    oy1 = span_t'($signed(req.old_y_max));
    nx0 = span_t'($signed(req.new_x_min));
    ny0 = span_t'($signed(req.new_y_min));
    nx1 = span_t'($signed(req.new_x_max));
    ny1 = span_t'($signed(req.new_y_max));
    old_ok = (ox1 >= ox0) && (oy1 >= oy0);
    new_ok = (nx1 >= nx0) && (ny1 >= ny0);
    w = screen_span(width_q);
    h = screen_span(height_q);
    if (old_ok) begin
      if (new_ok) begin
        top_end      = lesser(oy1, greater(oy0, ny0) - span_t'(1));
        bottom_start = greater(oy0, lesser(oy1, ny1) + span_t'(1));
      end else begin
        // Without a new rectangle the whole old area goes out as the top band.
        top_end      = oy1;
        bottom_start = oy1 + span_t'(1);
      end
      cands = {cands, area_t'{ox0, oy0, ox1, top_end, KIND_TOP}};
      cands = {cands, area_t'{ox0, bottom_start, ox1, oy1, KIND_BOTTOM}};
      if (new_ok) begin
        cands = {cands, area_t'{ox0, top_end + span_t'(1), lesser(ox1, nx0 - span_t'(1)),
                                bottom_start - span_t'(1), KIND_LEFT}};
        cands = {cands, area_t'{greater(ox0, nx1 + span_t'(1)), top_end + span_t'(1), ox1,
                                bottom_start - span_t'(1), KIND_RIGHT}};
      end
    end
    if (new_ok) cands = {cands, area_t'{nx0, ny0, nx1, ny1, KIND_NEW}};
    foreach (cands[i]) begin
      a = cands[i];
      if (a.x1 >= a.x0 && a.y1 >= a.y0 && a.x1 >= 0 && a.x0 < w && a.y1 >= 0 && a.y0 < h)
      begin
        lx = (a.x0 < 0) ? span_t'(0) : a.x0;
        ly = (a.y0 < 0) ? span_t'(0) : a.y0;
        hx = (a.x1 >= w) ? w - span_t'(1) : a.x1;
        hy = (a.y1 >= h) ? h - span_t'(1) : a.y1;
        r.region_x_min = lx[SCREEN_BITS-1:0];
        r.region_y_min = ly[SCREEN_BITS-1:0];
        r.region_x_max = hx[SCREEN_BITS-1:0];
        r.region_y_max = hy[SCREEN_BITS-1:0];
        r.region_kind  = a.kind;
        r.last_region  = 1'b0;
        found = {found, r};
      end
    end
    if (found.size() > 0) found[found.size()-1].last_region = 1'b1;
    foreach (found[i]) pending_regions = {pending_regions, found[i]};
  endfunction

  function void check_region(drs_result_t got);
    drs_result_t want;
    bit          bad;
    bad = 1'b0;
    if (pending_regions.size() == 0) begin
      $error("region %h arrived with no region expected", got);
      mismatch_count++;
      return;
    end
    want = pending_regions.pop_front();
    if (got.region_x_min !== want.region_x_min) begin
      $error("region_x_min: expected %0d, actual %0d", want.region_x_min, got.region_x_min);
      bad = 1'b1;
    end
    if (got.region_y_min !== want.region_y_min) begin
      $error("region_y_min: expected %0d, actual %0d", want.region_y_min, got.region_y_min);
      bad = 1'b1;
    end
    if (got.region_x_max !== want.region_x_max) begin
      $error("region_x_max: expected %0d, actual %0d", want.region_x_max, got.region_x_max);
      bad = 1'b1;
    end
    if (got.region_y_max !== want.region_y_max) begin
      $error("region_y_max: expected %0d, actual %0d", want.region_y_max, got.region_y_max);
      bad = 1'b1;
    end
    if (got.region_kind !== want.region_kind) begin
      $error("region_kind: expected %0d, actual %0d", want.region_kind, got.region_kind);
      bad = 1'b1;
    end
    if (got.last_region !== want.last_region) begin
      $error("last_region: expected %0d, actual %0d", want.last_region, got.last_region);
      bad = 1'b1;
    end
    if (bad) mismatch_count++;
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 7;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  drs_request_t            rect = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    result_valid;
  drs_result_t             result;

  region_scoreboard sb = new();
  int unsigned      cycle_count = 0;
  int               burst_left = 0;
  int               span_x = 240;
  int               span_y = 320;

  dirty_region_splitter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rect         (rect),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_request(rect);
    if (!rst && result_valid) sb.check_region(result);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic drs_request_t make_request(int ox0, int oy0, int ox1, int oy1,
                                                int nx0, int ny0, int nx1, int ny1);
    drs_request_t req;
    req.old_x_min = COORD_BITS'(ox0);
    req.old_y_min = COORD_BITS'(oy0);
    req.old_x_max = COORD_BITS'(ox1);
    req.old_y_max = COORD_BITS'(oy1);
    req.new_x_min = COORD_BITS'(nx0);
    req.new_y_min = COORD_BITS'(ny0);
    req.new_x_max = COORD_BITS'(nx1);
    req.new_y_max = COORD_BITS'(ny1);
    return req;
  endfunction

  // Mostly around the visible area, now and then an extreme or any 16-bit value.
  function automatic int near_coord(int s);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return -32768;
    if (pick == 1) return 32767;
    if (pick == 2) return int'($signed(COORD_BITS'($urandom)));
    return int'($urandom_range(0, s + 80)) - 40;
  endfunction

  function automatic drs_request_t random_request(int sx, int sy);
    int ox0, oy0, ox1, oy1, nx0, ny0, nx1, ny1, d;
    ox0 = near_coord(sx);
    oy0 = near_coord(sy);
    ox1 = ox0 + int'($urandom_range(0, sx / 2 + 2));
    oy1 = oy0 + int'($urandom_range(0, sy / 2 + 2));
    d   = ($urandom_range(0, 1) == 0) ? 4 : sx / 3 + 1;
    nx0 = ox0 + int'($urandom_range(0, 2 * d)) - d;
    ny0 = oy0 + int'($urandom_range(0, 2 * d)) - d;
    nx1 = nx0 + (ox1 - ox0) + int'($urandom_range(0, 8)) - 4;
    ny1 = ny0 + (oy1 - oy0) + int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom, $urandom, $urandom};
      1: begin
        if ($urandom_range(0, 1) == 0) ox1 = ox0 - 1 - int'($urandom_range(0, 20));
        else oy1 = oy0 - 1 - int'($urandom_range(0, 20));
      end
      2: begin
        if ($urandom_range(0, 1) == 0) nx1 = nx0 - 1 - int'($urandom_range(0, 20));
        else ny1 = ny0 - 1 - int'($urandom_range(0, 20));
      end
      3: begin
        nx0 = near_coord(sx);
        ny0 = near_coord(sy);
        nx1 = nx0 + int'($urandom_range(0, sx / 2 + 2));
        ny1 = ny0 + int'($urandom_range(0, sy / 2 + 2));
      end
      default: ;
    endcase
    return make_request(ox0, oy0, ox1, oy1, nx0, ny0, nx1, ny1);
  endfunction

  task automatic send_request(input drs_request_t req);
    start <= 1'b1;
    rect  <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The sender runs in bursts; between bursts start is low and rect carries noise.
  task automatic send_paced(input drs_request_t req);
    if (burst_left == 0) begin
      start <= 1'b0;
      rect  <= {$urandom, $urandom, $urandom, $urandom};
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    send_request(req);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_regions.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_screen(idx, val);
  endtask

  task automatic set_screen_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                                 input bit touch_spare);
    write_register(REG_SCREEN_WIDTH, w);
    write_register(REG_SCREEN_HEIGHT, h);
    if (touch_spare) write_register(REG_SPARE, CFG_BITS'($urandom));
    cfg_valid <= 1'b0;
    span_x = (w == 0) ? 64 : ((w > SCREEN_LIM) ? SCREEN_LIM : int'(w));
    span_y = (h == 0) ? 64 : ((h > SCREEN_LIM) ? SCREEN_LIM : int'(h));
  endtask

  task automatic run_directed();
    send_paced(make_request(20, 30, 59, 69, 20, 30, 59, 69));
    send_paced(make_request(10, 20, 49, 59, 20, 20, 59, 59));
    send_paced(make_request(10, 20, 49, 59, 0, 20, 39, 59));
    send_paced(make_request(10, 20, 49, 59, 10, 30, 49, 69));
    send_paced(make_request(10, 20, 49, 59, 10, 10, 49, 49));
    send_paced(make_request(10, 20, 109, 119, 40, 50, 59, 69));
    send_paced(make_request(10, 20, 49, 59, 150, 200, 189, 239));
    send_paced(make_request(10, 20, 49, 59, 150, 200, 149, 239));
    send_paced(make_request(50, 20, 49, 59, 150, 200, 189, 239));
    send_paced(make_request(50, 20, 49, 59, 30, 20, 40, 19));
    send_paced(make_request(-100, -50, -1, 100, 5, 5, 6, 6));
    send_paced(make_request(-100, -50, -1, -1, -30, -20, 100, -1));
    send_paced(make_request(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    send_paced(make_request(-32768, -32768, 32767, 32767, 0, 0, -32768, 10));
    send_paced(make_request(-32768, -32768, 32767, 32767, 100, 100, 120, 140));
    send_paced(make_request(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_paced(make_request(200, 300, 300, 400, 220, 310, 320, 410));
    send_paced(make_request(0, 0, 0, 0, 239, 319, 239, 319));
    send_paced(make_request(240, 0, 300, 10, 0, 320, 10, 400));
    send_paced(make_request(-10, -10, 0, 0, 239, 319, 500, 500));
    send_paced(make_request(0, 0, 239, 319, 1, 1, 238, 318));
  endtask

  initial begin
    int unsigned phase_w[NUM_PHASES];
    int unsigned phase_h[NUM_PHASES];
    int          phase_items[NUM_PHASES];
    phase_w = '{240, 4096, 1, 8191, 0, 0, 0};
    phase_h = '{320, 4096, 1, 8191, 77, 0, 0};
    phase_items = '{60, 55, 45, 45, 40, 45, 45};
    phase_w[5] = $urandom_range(1, 400);
    phase_h[5] = $urandom_range(1, 400);
    phase_w[6] = $urandom_range(1, 4096);
    phase_h[6] = $urandom_range(1, 600);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The first phase runs on the screen size left by reset.
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        set_screen_size(CFG_BITS'(phase_w[p]), CFG_BITS'(phase_h[p]), p == 1);
      end
      repeat (phase_items[p]) send_paced(random_request(span_x, span_y));
    end
    // Back to the reset size so that the width and height registers are rewritten too.
    wait_idle();
    set_screen_size(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET, 1'b0);
    repeat (20) send_paced(random_request(span_x, span_y));
    wait_idle();
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/drs_pkg.sv
rtl/drs_region_calc.sv
rtl/drs_region_queue.sv
rtl/dirty_region_splitter_unit.sv
tb/sv/tb.sv
